### rtl/pwsfd_pkg.sv
// Package for the pulse width sensor frame decoder.
// Holds field widths, action, status and register index codes, and the window bound types.
// No dependencies.
package pwsfd_pkg;

   localparam int DataWidth   = 16;
   localparam int ActionWidth = 2;
   localparam int StatusWidth = 3;
   localparam int IndexWidth  = 3;
   localparam int FrameBytes  = 5;
   localparam int FrameBits   = FrameBytes * 8;
   localparam int CountWidth  = 6;

   // action codes
   localparam logic [ActionWidth-1:0] ACT_ARM        = 2'd0;
   localparam logic [ActionWidth-1:0] ACT_PULSE      = 2'd1;
   localparam logic [ActionWidth-1:0] ACT_EDGE_TMO   = 2'd2;
   localparam logic [ActionWidth-1:0] ACT_PACKET_TMO = 2'd3;

   // status codes
   localparam logic [StatusWidth-1:0] ST_OK         = 3'd0;
   localparam logic [StatusWidth-1:0] ST_EDGE_TMO   = 3'd1;
   localparam logic [StatusWidth-1:0] ST_OVERFLOW   = 3'd2;
   localparam logic [StatusWidth-1:0] ST_DECODE_ERR = 3'd3;
   localparam logic [StatusWidth-1:0] ST_CHECKSUM   = 3'd4;
   localparam logic [StatusWidth-1:0] ST_PACKET_TMO = 3'd5;

   // register indexes
   localparam logic [IndexWidth-1:0] REG_START_LOW  = 3'd0;
   localparam logic [IndexWidth-1:0] REG_START_HIGH = 3'd1;
   localparam logic [IndexWidth-1:0] REG_BIT_LOW    = 3'd2;
   localparam logic [IndexWidth-1:0] REG_ONE_HIGH   = 3'd3;
   localparam logic [IndexWidth-1:0] REG_ZERO_HIGH  = 3'd4;

   // register reset values, microseconds
   localparam logic [DataWidth-1:0] START_LOW_RESET  = 16'd80;
   localparam logic [DataWidth-1:0] START_HIGH_RESET = 16'd80;
   localparam logic [DataWidth-1:0] BIT_LOW_RESET    = 16'd50;
   localparam logic [DataWidth-1:0] ONE_HIGH_RESET   = 16'd70;
   localparam logic [DataWidth-1:0] ZERO_HIGH_RESET  = 16'd27;

   // acceptance window: lo <= v < hi
   typedef struct packed {
      logic [DataWidth-1:0] lo;
      logic [DataWidth:0]   hi;
   } window_type;

   typedef struct packed {
      window_type start_low;
      window_type start_high;
      window_type bit_low;
      window_type one_high;
      window_type zero_high;
   } bounds_type;

endpackage

### rtl/pulse_width_sensor_frame_decoder.sv
// Top level of the pulse width sensor frame decoder.
// Depends on pwsfd_pkg and pwsfd_bounds.
//
// Usage:
//   req_* carries one word per event: arm, captured pulse (low width and
//   period in microseconds, period 0 = counter overflow), edge timeout or
//   packet timeout. rsp_* carries one status word with the decoded reading
//   at the end of a frame or on an error; most request words yield none.
//   csr_* writes the five nominal timing registers (index 0..4); write them
//   only while the decoder is idle. Each written value becomes a window of
//   nominal +/- nominal/TOL_DIV, computed once at write time.
// Timing:
//   A request word lands in the input register, and its response word, if
//   any, moves into the response register when the input register drains;
//   a held response word can stall it in between. One word per cycle while
//   no response word is held; the decode is five window compares, a 40-bit
//   shift and an 8-bit byte sum.
// Reset:
//   Decoder goes idle with an empty frame, timing registers return to
//   80/80/50/70/27 us.
// Stall:
//   A held response word stalls the input register, and req_ready drops
//   only when both the input and response registers are full and rsp_ready
//   is low.
module pulse_width_sensor_frame_decoder #(
   parameter int TOL_DIV = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pwsfd_pkg::ActionWidth-1:0]    req_action,
   input  logic [pwsfd_pkg::DataWidth-1:0]      req_pulse_low_us,
   input  logic [pwsfd_pkg::DataWidth-1:0]      req_pulse_period_us,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pwsfd_pkg::StatusWidth-1:0]    rsp_status,
   output logic [pwsfd_pkg::DataWidth-1:0]      rsp_humidity,
   output logic signed [pwsfd_pkg::DataWidth-1:0] rsp_temperature,
   output logic                                 rsp_short_format,
   // configuration port
   input  logic                                 csr_we,
   input  logic [pwsfd_pkg::IndexWidth-1:0]     csr_index,
   input  logic [pwsfd_pkg::DataWidth-1:0]      csr_wdata
);

   // decoder phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_BITS  = 2'd2;

   localparam int FB = pwsfd_pkg::FrameBits;

   pwsfd_pkg::bounds_type bounds;

   // input register
   logic                                 in_valid_ff;
   logic [pwsfd_pkg::ActionWidth-1:0]    in_action_ff;
   logic [pwsfd_pkg::DataWidth-1:0]      in_low_ff;
   logic [pwsfd_pkg::DataWidth-1:0]      in_period_ff;

   // frame state
   logic [1:0]                           phase_ff, phase_in;
   logic [pwsfd_pkg::CountWidth-1:0]     bits_ff, bits_in;
   logic [FB-1:0]                        shift_ff, shift_in;

   // response register
   logic                                 rsp_valid_ff;
   logic [pwsfd_pkg::StatusWidth-1:0]    status_ff, status_in;
   logic [pwsfd_pkg::DataWidth-1:0]      hum_ff, hum_in;
   logic [pwsfd_pkg::DataWidth-1:0]      temp_ff, temp_in;
   logic                                 short_ff, short_in;
   logic                                 emit;

   logic                                 advance;
   logic [pwsfd_pkg::DataWidth-1:0]      high_us;
   logic                                 high_ok;
   logic                                 start_ok, one_ok, zero_ok, bit_low_ok;
   logic [FB-1:0]                        frame;
   logic [pwsfd_pkg::CountWidth-1:0]     bits_next;
   logic [7:0]                           b0, b1, b2, b3, b4, byte_sum;
   logic [14:0]                          mag;

   pwsfd_bounds #(
      .TOL_DIV (TOL_DIV)
   ) u_bounds (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bounds    (bounds)
   );

   function automatic logic in_win(
      input logic [pwsfd_pkg::DataWidth-1:0] v,
      input pwsfd_pkg::window_type           w
   );
      return (v >= w.lo) && ({1'b0, v} < w.hi);
   endfunction

   // the input register moves on whenever the response slot is free or draining
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_action_ff <= req_action;
         in_low_ff    <= req_pulse_low_us;
         in_period_ff <= req_pulse_period_us;
      end
   end

   // pulse classification; a low width past the period never matches
   assign high_us    = in_period_ff - in_low_ff;
   assign high_ok    = in_low_ff <= in_period_ff;
   assign start_ok   = high_ok && in_win(in_low_ff, bounds.start_low)
                       && in_win(high_us, bounds.start_high);
   assign bit_low_ok = high_ok && in_win(in_low_ff, bounds.bit_low);
   assign one_ok     = bit_low_ok && in_win(high_us, bounds.one_high);
   assign zero_ok    = bit_low_ok && in_win(high_us, bounds.zero_high);

   // frame with the current bit shifted in (one wins over zero)
   assign frame     = {shift_ff[FB-2:0], one_ok};
   assign bits_next = bits_ff + 1'b1;

   assign b0       = frame[39:32];
   assign b1       = frame[31:24];
   assign b2       = frame[23:16];
   assign b3       = frame[15:8];
   assign b4       = frame[7:0];
   assign byte_sum = b0 + b1 + b2 + b3;
   assign mag      = {b2[6:0], b3};

   always_comb begin
      phase_in  = phase_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      emit      = 1'b0;
      status_in = pwsfd_pkg::ST_OK;
      hum_in    = '0;
      temp_in   = '0;
      short_in  = 1'b0;
      priority if (in_action_ff == pwsfd_pkg::ACT_ARM) begin
         // restart the read, no response
         phase_in = PH_START;
         bits_in  = '0;
         shift_in = '0;
      end else if (phase_ff == PH_IDLE) begin
         // drop pulses and timeouts while idle
      end else if (in_action_ff == pwsfd_pkg::ACT_EDGE_TMO ||
                   in_action_ff == pwsfd_pkg::ACT_PACKET_TMO ||
                   in_period_ff == '0) begin
         phase_in  = PH_IDLE;
         bits_in   = '0;
         shift_in  = '0;
         emit      = 1'b1;
         status_in = (in_action_ff == pwsfd_pkg::ACT_EDGE_TMO) ? pwsfd_pkg::ST_EDGE_TMO :
                     (in_action_ff == pwsfd_pkg::ACT_PACKET_TMO) ? pwsfd_pkg::ST_PACKET_TMO :
                     pwsfd_pkg::ST_OVERFLOW;
      end else if (phase_ff == PH_START) begin
         bits_in  = '0;
         shift_in = '0;
         if (start_ok) begin
            phase_in = PH_BITS;
         end else begin
            phase_in  = PH_IDLE;
            emit      = 1'b1;
            status_in = pwsfd_pkg::ST_DECODE_ERR;
         end
      end else if (!(one_ok || zero_ok)) begin
         phase_in  = PH_IDLE;
         bits_in   = '0;
         shift_in  = '0;
         emit      = 1'b1;
         status_in = pwsfd_pkg::ST_DECODE_ERR;
      end else if (bits_next >= pwsfd_pkg::CountWidth'(FB)) begin
         // last bit: check the byte sum and report
         phase_in = PH_IDLE;
         bits_in  = '0;
         shift_in = '0;
         emit     = 1'b1;
         if (byte_sum != b4) begin
            status_in = pwsfd_pkg::ST_CHECKSUM;
         end else if (b1 == '0 && b3 == '0) begin
            hum_in   = {8'd0, b0};
            temp_in  = {8'd0, b2};
            short_in = 1'b1;
         end else begin
            hum_in  = {b0, b1};
            temp_in = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
         end
      end else begin
         bits_in  = bits_next;
         shift_in = frame;
      end
   end

   // commit state and response as the input register drains
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bits_ff      <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && emit;
         if (in_valid_ff) begin
            phase_ff <= phase_in;
            bits_ff  <= bits_in;
            shift_ff <= shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && emit) begin
         status_ff <= status_in;
         hum_ff    <= hum_in;
         temp_ff   <= temp_in;
         short_ff  <= short_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_humidity     = hum_ff;
   assign rsp_temperature  = temp_ff;
   assign rsp_short_format = short_ff;

   // bit count never reaches a full frame; it wraps to idle on the last bit
   a_bits_below_frame: assert property (@(posedge clock) disable iff (reset)
      bits_ff < pwsfd_pkg::CountWidth'(FB))
      else $error("bit count reached frame length");

   // collected bits only exist while receiving
   a_bits_only_receiving: assert property (@(posedge clock) disable iff (reset)
      (bits_ff != '0 || shift_ff != '0) |-> phase_ff == PH_BITS)
      else $error("frame bits outside receive phase");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE || phase_ff == PH_START || phase_ff == PH_BITS)
      else $error("unused phase code");

   // a stalled input word keeps its payload
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_action_ff)
                                     && $stable(in_low_ff) && $stable(in_period_ff)))
      else $error("input register changed while stalled");

   // error responses carry no reading
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != pwsfd_pkg::ST_OK) |->
         (hum_ff == '0 && temp_ff == '0 && !short_ff))
      else $error("error response with nonzero reading");

endmodule

### rtl/pwsfd_bounds.sv
// Timing registers of the frame decoder, kept as precomputed window bounds.
// Depends on pwsfd_pkg.
module pwsfd_bounds #(
   parameter int TOL_DIV = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [pwsfd_pkg::IndexWidth-1:0]     csr_index,
   input  logic [pwsfd_pkg::DataWidth-1:0]      csr_wdata,
   output pwsfd_pkg::bounds_type                bounds
);

   // value / TOL_DIV as multiply by a rounded-up reciprocal, exact for 16-bit values
   localparam int RecipShift = pwsfd_pkg::DataWidth + $clog2(TOL_DIV);
   localparam int Recip      = ((1 << RecipShift) + TOL_DIV - 1) / TOL_DIV;
   localparam int RecipWidth = pwsfd_pkg::DataWidth + 2;
   localparam int ProdWidth  = pwsfd_pkg::DataWidth + RecipWidth;

   localparam logic [pwsfd_pkg::DataWidth-1:0] StartLowD  =
      16'(pwsfd_pkg::START_LOW_RESET / TOL_DIV);
   localparam logic [pwsfd_pkg::DataWidth-1:0] StartHighD =
      16'(pwsfd_pkg::START_HIGH_RESET / TOL_DIV);
   localparam logic [pwsfd_pkg::DataWidth-1:0] BitLowD    =
      16'(pwsfd_pkg::BIT_LOW_RESET / TOL_DIV);
   localparam logic [pwsfd_pkg::DataWidth-1:0] OneHighD   =
      16'(pwsfd_pkg::ONE_HIGH_RESET / TOL_DIV);
   localparam logic [pwsfd_pkg::DataWidth-1:0] ZeroHighD  =
      16'(pwsfd_pkg::ZERO_HIGH_RESET / TOL_DIV);

   pwsfd_pkg::bounds_type              bounds_ff;
   logic [ProdWidth-1:0]               prod;
   logic [pwsfd_pkg::DataWidth-1:0]    dev;
   pwsfd_pkg::window_type              win_in;

   function automatic pwsfd_pkg::window_type make_window(
      input logic [pwsfd_pkg::DataWidth-1:0] nom,
      input logic [pwsfd_pkg::DataWidth-1:0] d
   );
      pwsfd_pkg::window_type w;
      w.lo = nom - d;
      w.hi = {1'b0, nom} + {1'b0, d};
      return w;
   endfunction

   assign prod   = ProdWidth'(csr_wdata) * ProdWidth'(RecipWidth'(Recip));
   assign dev    = pwsfd_pkg::DataWidth'(prod >> RecipShift);
   assign win_in = make_window(csr_wdata, dev);

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.start_low  <= make_window(pwsfd_pkg::START_LOW_RESET, StartLowD);
         bounds_ff.start_high <= make_window(pwsfd_pkg::START_HIGH_RESET, StartHighD);
         bounds_ff.bit_low    <= make_window(pwsfd_pkg::BIT_LOW_RESET, BitLowD);
         bounds_ff.one_high   <= make_window(pwsfd_pkg::ONE_HIGH_RESET, OneHighD);
         bounds_ff.zero_high  <= make_window(pwsfd_pkg::ZERO_HIGH_RESET, ZeroHighD);
      end else if (csr_we) begin
         unique case (csr_index)
            pwsfd_pkg::REG_START_LOW:  bounds_ff.start_low  <= win_in;
            pwsfd_pkg::REG_START_HIGH: bounds_ff.start_high <= win_in;
            pwsfd_pkg::REG_BIT_LOW:    bounds_ff.bit_low    <= win_in;
            pwsfd_pkg::REG_ONE_HIGH:   bounds_ff.one_high   <= win_in;
            pwsfd_pkg::REG_ZERO_HIGH:  bounds_ff.zero_high  <= win_in;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   assign bounds = bounds_ff;

endmodule

### sim/pulse_width_sensor_frame_decoder_test.sv
// Self-checking testbench for pulse_width_sensor_frame_decoder: drives arm, pulse and
// timeout words, predicts each status word and compares it field by field.
// Depends on rtl/pwsfd_pkg.sv and rtl/pulse_width_sensor_frame_decoder.sv.
`timescale 1ns / 100ps

module pulse_width_sensor_frame_decoder_test;

   localparam int TolDiv      = 2;
   localparam int SettleCycles = 8;     // extra wait after the last status word
   localparam int DrainCycles  = 8;
   localparam int CycleLimit   = 600000;
   localparam int NumPhases    = 8;
   localparam int NumFixed     = 6;

   // out-of-range register index, the decoder must drop these writes
   localparam logic [pwsfd_pkg::IndexWidth-1:0] RegUnusedFirst = 3'd5;

   typedef enum logic [1:0] {DEC_IDLE, DEC_START, DEC_BITS} decode_phase_type;

   typedef struct packed {
      logic [pwsfd_pkg::StatusWidth-1:0]      status;
      logic [pwsfd_pkg::DataWidth-1:0]        humidity;
      logic signed [pwsfd_pkg::DataWidth-1:0] temperature;
      logic                                   short_format;
   } reading_type;

   typedef struct packed {
      logic [pwsfd_pkg::ActionWidth-1:0] action;
      logic [pwsfd_pkg::DataWidth-1:0]   low_us;
      logic [pwsfd_pkg::DataWidth-1:0]   period_us;
      logic                              typed;    // expectation typed in below
      logic                              yields;   // typed row produces a status word
      reading_type                       want;
   } stim_row_type;

   localparam reading_type Quiet     = '{pwsfd_pkg::ST_OK, 16'd0, 16'sd0, 1'b0};
   localparam reading_type DecodeErr = '{pwsfd_pkg::ST_DECODE_ERR, 16'd0, 16'sd0, 1'b0};
   localparam reading_type Overflow  = '{pwsfd_pkg::ST_OVERFLOW, 16'd0, 16'sd0, 1'b0};
   localparam reading_type EdgeErr   = '{pwsfd_pkg::ST_EDGE_TMO, 16'd0, 16'sd0, 1'b0};
   localparam reading_type PacketErr = '{pwsfd_pkg::ST_PACKET_TMO, 16'd0, 16'sd0, 1'b0};

   // Directed words, reset timing: start 80/80, bit low 50, one 70, zero 27.
   localparam stim_row_type DirectedRows [25] = '{
      '{pwsfd_pkg::ACT_PULSE,      16'd80,   16'd160,  1'b1, 1'b0, Quiet},  // pulse while idle
      '{pwsfd_pkg::ACT_EDGE_TMO,   16'd0,    16'd0,    1'b1, 1'b0, Quiet},  // timeouts while idle
      '{pwsfd_pkg::ACT_PACKET_TMO, 16'hffff, 16'hffff, 1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_ARM,        16'hffff, 16'hffff, 1'b1, 1'b0, Quiet},  // re-arm restarts
      '{pwsfd_pkg::ACT_PULSE,      16'd200,  16'd100,  1'b1, 1'b1, DecodeErr}, // low above period
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_PULSE,      16'd0,    16'd0,    1'b1, 1'b1, Overflow},
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_EDGE_TMO,   16'd80,   16'd160,  1'b1, 1'b1, EdgeErr},
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_PACKET_TMO, 16'd80,   16'd160,  1'b1, 1'b1, PacketErr},
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_PULSE,      16'hffff, 16'hffff, 1'b1, 1'b1, DecodeErr}, // zero high width
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_PULSE,      16'd80,   16'd160,  1'b0, 1'b0, Quiet},  // nominal start
      '{pwsfd_pkg::ACT_PULSE,      16'hffff, 16'd0,    1'b1, 1'b1, Overflow}, // overflow mid-read
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_PULSE,      16'd40,   16'd80,   1'b0, 1'b0, Quiet},  // start, lower edges
      '{pwsfd_pkg::ACT_PULSE,      16'd50,   16'd120,  1'b0, 1'b0, Quiet},  // one bit
      '{pwsfd_pkg::ACT_PULSE,      16'd50,   16'd77,   1'b0, 1'b0, Quiet},  // zero bit
      '{pwsfd_pkg::ACT_PULSE,      16'd50,   16'd88,   1'b0, 1'b0, Quiet},  // both windows: one
      '{pwsfd_pkg::ACT_PULSE,      16'd75,   16'd102,  1'b1, 1'b1, DecodeErr}, // low at upper bound
      '{pwsfd_pkg::ACT_ARM,        16'd0,    16'd0,    1'b1, 1'b0, Quiet},
      '{pwsfd_pkg::ACT_PULSE,      16'd119,  16'd239,  1'b1, 1'b1, DecodeErr}  // high at upper bound
   };

   // hand-built frames: short format, sign bit, negative zero, bad checksum, all ones
   localparam logic [pwsfd_pkg::FrameBits-1:0] SeedFrames [7] = '{
      40'h37_00_17_00_4e, 40'h02_8c_80_65_73, 40'h01_00_80_00_81, 40'h01_02_03_04_0b,
      40'hff_ff_ff_ff_fc, 40'h00_00_00_00_00, 40'h00_01_80_00_81
   };

   localparam logic [pwsfd_pkg::IndexWidth-1:0] TimingRegs [5] = '{
      pwsfd_pkg::REG_START_LOW, pwsfd_pkg::REG_START_HIGH, pwsfd_pkg::REG_BIT_LOW,
      pwsfd_pkg::REG_ONE_HIGH, pwsfd_pkg::REG_ZERO_HIGH
   };

   // Row 0 is the reset timing and is never written; phases from NumFixed on are random.
   localparam logic [pwsfd_pkg::DataWidth-1:0] FixedTiming [NumFixed][5] = '{
      '{16'd80, 16'd80, 16'd50, 16'd70, 16'd27},
      '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1},
      '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
      '{16'd2, 16'd3, 16'd2, 16'd4, 16'd2},
      '{16'd80, 16'd80, 16'd50, 16'd70, 16'd0},
      '{16'd20000, 16'd20000, 16'd10000, 16'd30000, 16'd12000}
   };

   localparam int PhaseWords [NumPhases] = '{90, 25, 25, 90, 50, 120, 150, 150};
   localparam int ReqIdlePct [3] = '{0, 8, 25};
   localparam int RspIdlePct [3] = '{0, 3, 10};

   logic clock;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [pwsfd_pkg::ActionWidth-1:0] req_action = pwsfd_pkg::ACT_ARM;
   logic [pwsfd_pkg::DataWidth-1:0]   req_pulse_low_us = '0;
   logic [pwsfd_pkg::DataWidth-1:0]   req_pulse_period_us = '0;

   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [pwsfd_pkg::StatusWidth-1:0]      rsp_status;
   logic [pwsfd_pkg::DataWidth-1:0]        rsp_humidity;
   logic signed [pwsfd_pkg::DataWidth-1:0] rsp_temperature;
   logic                                   rsp_short_format;

   logic                             csr_we = 1'b0;
   logic [pwsfd_pkg::IndexWidth-1:0] csr_index = '0;
   logic [pwsfd_pkg::DataWidth-1:0]  csr_wdata = '0;

   // decoder state as the testbench sees it
   decode_phase_type                 decoder_phase;
   logic [pwsfd_pkg::CountWidth-1:0] bits_seen;
   logic [pwsfd_pkg::FrameBits-1:0]  frame_bits;
   logic [pwsfd_pkg::DataWidth-1:0]  nominal_us [5];

   reading_type pending_readings [$];

   int  mismatch_count   = 0;
   int  words_sent       = 0;
   int  readings_checked = 0;
   int  good_frames      = 0;
   int  short_frames     = 0;
   int  cycle_count      = 0;
   int  req_pct          = 0;
   int  rsp_pct          = 0;
   int  rsp_stall_left   = 0;
   bit  calm             = 1'b0;

   pulse_width_sensor_frame_decoder #(
      .TOL_DIV(TolDiv)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_pulse_low_us   (req_pulse_low_us),
      .req_pulse_period_us(req_pulse_period_us),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_humidity       (rsp_humidity),
      .rsp_temperature    (rsp_temperature),
      .rsp_short_format   (rsp_short_format),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   // A width fits when it lies in [nom - nom/TolDiv, nom + nom/TolDiv).
   function automatic bit fits_window(input int v, input int nom);
      int d;
      d = nom / TolDiv;
      return v >= nom - d && v < nom + d;
   endfunction

   function automatic bit pulse_matches(input logic [pwsfd_pkg::DataWidth-1:0] low_us,
                                        input logic [pwsfd_pkg::DataWidth-1:0] period_us,
                                        input logic [pwsfd_pkg::DataWidth-1:0] nom_low,
                                        input logic [pwsfd_pkg::DataWidth-1:0] nom_high);
      if (low_us > period_us) return 1'b0;
      return fits_window(low_us, nom_low) && fits_window(period_us - low_us, nom_high);
   endfunction

   function automatic void drop_frame();
      decoder_phase = DEC_IDLE;
      bits_seen     = '0;
      frame_bits    = '0;
   endfunction

   // Advance the decoder by one word; return 1 when it emits a status word.
   function automatic bit decode_word(input logic [pwsfd_pkg::ActionWidth-1:0] act,
                                      input logic [pwsfd_pkg::DataWidth-1:0] low_us,
                                      input logic [pwsfd_pkg::DataWidth-1:0] period_us,
                                      output reading_type rd);
      logic [7:0]                     b [pwsfd_pkg::FrameBytes];
      logic [7:0]                     sum;
      logic [pwsfd_pkg::DataWidth-1:0] raw;
      logic [pwsfd_pkg::DataWidth-1:0] mag;
      logic                           bit_val;
      rd = Quiet;
      if (act == pwsfd_pkg::ACT_ARM) begin
         drop_frame();
         decoder_phase = DEC_START;
         return 1'b0;
      end
      if (decoder_phase == DEC_IDLE) return 1'b0;
      if (act == pwsfd_pkg::ACT_EDGE_TMO || act == pwsfd_pkg::ACT_PACKET_TMO ||
          period_us == '0) begin
         rd.status = (act == pwsfd_pkg::ACT_EDGE_TMO) ? pwsfd_pkg::ST_EDGE_TMO :
                     (act == pwsfd_pkg::ACT_PACKET_TMO) ? pwsfd_pkg::ST_PACKET_TMO :
                     pwsfd_pkg::ST_OVERFLOW;
         drop_frame();
         return 1'b1;
      end
      if (decoder_phase == DEC_START) begin
         if (pulse_matches(low_us, period_us, nominal_us[pwsfd_pkg::REG_START_LOW],
                           nominal_us[pwsfd_pkg::REG_START_HIGH])) begin
            decoder_phase = DEC_BITS;
            bits_seen     = '0;
            frame_bits    = '0;
            return 1'b0;
         end
         rd.status = pwsfd_pkg::ST_DECODE_ERR;
         drop_frame();
         return 1'b1;
      end
      // one window has priority over zero window
      if (pulse_matches(low_us, period_us, nominal_us[pwsfd_pkg::REG_BIT_LOW],
                        nominal_us[pwsfd_pkg::REG_ONE_HIGH]))
         bit_val = 1'b1;
      else if (pulse_matches(low_us, period_us, nominal_us[pwsfd_pkg::REG_BIT_LOW],
                             nominal_us[pwsfd_pkg::REG_ZERO_HIGH]))
         bit_val = 1'b0;
      else begin
         rd.status = pwsfd_pkg::ST_DECODE_ERR;
         drop_frame();
         return 1'b1;
      end
      frame_bits = {frame_bits[pwsfd_pkg::FrameBits-2:0], bit_val};
      bits_seen  = bits_seen + 1'b1;
      if (bits_seen < pwsfd_pkg::FrameBits) return 1'b0;

      for (int i = 0; i < pwsfd_pkg::FrameBytes; i++)
         b[i] = frame_bits[pwsfd_pkg::FrameBits-1-8*i -: 8];
      sum = b[0] + b[1] + b[2] + b[3];
      drop_frame();
      if (sum != b[4]) begin
         rd.status = pwsfd_pkg::ST_CHECKSUM;
      end else if (b[1] == 8'd0 && b[3] == 8'd0) begin
         rd.humidity     = {8'd0, b[0]};
         rd.temperature  = {8'd0, b[2]};
         rd.short_format = 1'b1;
      end else begin
         raw            = {b[2], b[3]};
         mag            = {1'b0, raw[14:0]};
         rd.humidity    = {b[0], b[1]};
         rd.temperature = raw[15] ? -mag : mag;    // sign-magnitude to two's complement
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- request side

   // Present one word, hold it until accepted, then advance the prediction.
   // Typed rows push their own expectation instead of the predicted one.
   task automatic send_word(input logic [pwsfd_pkg::ActionWidth-1:0] act,
                            input logic [pwsfd_pkg::DataWidth-1:0] low_us,
                            input logic [pwsfd_pkg::DataWidth-1:0] period_us,
                            input bit typed = 1'b0, input bit typed_yields = 1'b0,
                            input reading_type typed_want = '0);
      reading_type predicted;
      bit          yields;
      if (!calm && $urandom_range(99) < req_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(18, 1)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_action          <= act;
      req_pulse_low_us    <= low_us;
      req_pulse_period_us <= period_us;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // words ignored by an idle decoder do not count toward the budget
      if (act == pwsfd_pkg::ACT_ARM || decoder_phase != DEC_IDLE) words_sent++;
      yields = decode_word(act, low_us, period_us, predicted);
      if (typed) begin
         if (typed_yields) pending_readings.push_back(typed_want);
      end else if (yields) begin
         pending_readings.push_back(predicted);
      end
   endtask

   // Pick a width inside the window of nom, often right on one of its edges.
   function automatic int pick_width(input logic [pwsfd_pkg::DataWidth-1:0] nom);
      int n;
      int lo_b;
      int hi_b;
      int r;
      n    = nom;
      lo_b = n - n / TolDiv;
      hi_b = n + n / TolDiv - 1;
      if (hi_b < lo_b) return n;     // empty window, the pulse will be rejected
      if (hi_b > 65535) hi_b = 65535;
      r = $urandom_range(7);
      if (r == 0) return lo_b;
      if (r == 1) return hi_b;
      return $urandom_range(hi_b, lo_b);
   endfunction

   function automatic void make_pulse(input int low, input int high,
                                      output logic [pwsfd_pkg::DataWidth-1:0] low_us,
                                      output logic [pwsfd_pkg::DataWidth-1:0] period_us);
      int total;
      total     = low + high;
      low_us    = low[pwsfd_pkg::DataWidth-1:0];
      period_us = (total > 65535) ? 16'hffff : total[pwsfd_pkg::DataWidth-1:0];
   endfunction

   // Break a frame: timeout, overflow, restart, near-miss or garbage pulse.
   task automatic send_broken();
      int near;
      case ($urandom_range(5))
         0: send_word(pwsfd_pkg::ACT_EDGE_TMO, 16'($urandom), 16'($urandom));
         1: send_word(pwsfd_pkg::ACT_PACKET_TMO, 16'($urandom), 16'($urandom));
         2: send_word(pwsfd_pkg::ACT_PULSE, 16'($urandom), 16'd0);
         3: send_word(pwsfd_pkg::ACT_ARM, 16'($urandom), 16'($urandom));
         4: begin
            // low width one below the bit-low window
            near = nominal_us[pwsfd_pkg::REG_BIT_LOW]
                   - nominal_us[pwsfd_pkg::REG_BIT_LOW] / TolDiv - 1;
            if (near < 0) near = 0;
            send_word(pwsfd_pkg::ACT_PULSE, near[pwsfd_pkg::DataWidth-1:0],
                      16'(near + pick_width(nominal_us[pwsfd_pkg::REG_ONE_HIGH])));
         end
         default: send_word(pwsfd_pkg::ACT_PULSE, 16'($urandom), 16'($urandom));
      endcase
   endtask

   // Arm, start pulse, then 40 bit pulses MSB first; cut short at break_at if >= 0.
   task automatic send_frame(input logic [pwsfd_pkg::FrameBits-1:0] frame,
                             input int break_at);
      logic [pwsfd_pkg::DataWidth-1:0] low_us;
      logic [pwsfd_pkg::DataWidth-1:0] period_us;
      int                              high;
      send_word(pwsfd_pkg::ACT_ARM, 16'($urandom), 16'($urandom));
      for (int k = 0; k <= pwsfd_pkg::FrameBits; k++) begin
         if (k == break_at) begin
            send_broken();
            return;
         end
         if (k == 0) begin
            high = pick_width(nominal_us[pwsfd_pkg::REG_START_HIGH]);
         end else if (frame[pwsfd_pkg::FrameBits-k]) begin
            high = pick_width(nominal_us[pwsfd_pkg::REG_ONE_HIGH]);
         end else begin
            // steer zero bits out of the one window where the windows overlap
            high = pick_width(nominal_us[pwsfd_pkg::REG_ZERO_HIGH]);
            for (int t = 0; t < 4 && fits_window(high, nominal_us[pwsfd_pkg::REG_ONE_HIGH]);
                 t++)
               high = pick_width(nominal_us[pwsfd_pkg::REG_ZERO_HIGH]);
         end
         make_pulse(pick_width(k == 0 ? nominal_us[pwsfd_pkg::REG_START_LOW]
                                      : nominal_us[pwsfd_pkg::REG_BIT_LOW]),
                    high, low_us, period_us);
         send_word(pwsfd_pkg::ACT_PULSE, low_us, period_us);
      end
   endtask

   // Random content: some short format, some negative, a few bad checksums.
   function automatic logic [pwsfd_pkg::FrameBits-1:0] random_frame();
      logic [7:0] b [pwsfd_pkg::FrameBytes];
      int         r;
      for (int i = 0; i < 4; i++) b[i] = 8'($urandom);
      r = $urandom_range(99);
      if (r < 30) begin
         b[1] = 8'd0;
         b[3] = 8'd0;
      end else if (r < 50) begin
         b[2][7] = 1'b1;
      end
      b[4] = b[0] + b[1] + b[2] + b[3];
      if ($urandom_range(99) < 10) b[4] = b[4] ^ 8'($urandom_range(255, 1));
      return {b[0], b[1], b[2], b[3], b[4]};
   endfunction

   // Single stray word with any action and any field values.
   task automatic send_noise();
      logic [pwsfd_pkg::DataWidth-1:0] period_us;
      period_us = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
      send_word(2'($urandom_range(3)), 16'($urandom), period_us);
   endtask

   // Close any open read, then wait for every status word and for the pipe to empty.
   task automatic settle();
      if (decoder_phase != DEC_IDLE)
         send_word(pwsfd_pkg::ACT_EDGE_TMO, 16'($urandom), 16'($urandom));
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write all five timing registers plus one unused index that must be ignored.
   task automatic load_timing(input int p);
      logic [pwsfd_pkg::DataWidth-1:0]  value;
      logic [pwsfd_pkg::IndexWidth-1:0] idx;
      for (int r = 0; r < 6; r++) begin
         if (r < 5) begin
            idx = TimingRegs[r];
            if (p < NumFixed) begin
               value = FixedTiming[p][r];
            end else begin
               case (idx)
                  pwsfd_pkg::REG_BIT_LOW:   value = 16'($urandom_range(3000, 10));
                  pwsfd_pkg::REG_ONE_HIGH:  value = 16'($urandom_range(3000, 20));
                  pwsfd_pkg::REG_ZERO_HIGH: value = 16'($urandom_range(1500, 10));
                  default:                  value = 16'($urandom_range(5000, 10));
               endcase
            end
         end else begin
            idx   = RegUnusedFirst + 3'(p % 3);
            value = 16'($urandom);
         end
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         if (idx <= pwsfd_pkg::REG_ZERO_HIGH) nominal_us[idx] = value;
      end
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- response side

   task automatic note_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch, %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_reading(input reading_type got);
      reading_type want;
      if (pending_readings.size() == 0) begin
         note_mismatch("status word with nothing pending, status", got.status, 0);
         return;
      end
      want = pending_readings.pop_front();
      readings_checked++;
      if (got.status !== want.status) note_mismatch("status", got.status, want.status);
      if (got.humidity !== want.humidity) note_mismatch("humidity", got.humidity, want.humidity);
      if (got.temperature !== want.temperature)
         note_mismatch("temperature", got.temperature, want.temperature);
      if (got.short_format !== want.short_format)
         note_mismatch("short_format", got.short_format, want.short_format);
      if (want.status == pwsfd_pkg::ST_OK) begin
         good_frames++;
         if (want.short_format) short_frames++;
      end
   endtask

   // Take status words and stall in random bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_reading(reading_type'{rsp_status, rsp_humidity, rsp_temperature,
                                        rsp_short_format});
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < rsp_pct) begin
            rsp_stall_left = $urandom_range(17, 0);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d status words pending",
                  cycle_count, pending_readings.size());
         $display("pulse_width_sensor_frame_decoder_test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int first_word;
      drop_frame();
      nominal_us[pwsfd_pkg::REG_START_LOW]  = pwsfd_pkg::START_LOW_RESET;
      nominal_us[pwsfd_pkg::REG_START_HIGH] = pwsfd_pkg::START_HIGH_RESET;
      nominal_us[pwsfd_pkg::REG_BIT_LOW]    = pwsfd_pkg::BIT_LOW_RESET;
      nominal_us[pwsfd_pkg::REG_ONE_HIGH]   = pwsfd_pkg::ONE_HIGH_RESET;
      nominal_us[pwsfd_pkg::REG_ZERO_HIGH]  = pwsfd_pkg::ZERO_HIGH_RESET;

      // hold reset, then release on a clock edge
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words against the reset timing
      for (int i = 0; i < 25; i++)
         send_word(DirectedRows[i].action, DirectedRows[i].low_us, DirectedRows[i].period_us,
                   DirectedRows[i].typed, DirectedRows[i].yields, DirectedRows[i].want);
      for (int i = 0; i < 7; i++) send_frame(SeedFrames[i], -1);

      // Random part, one timing setting per phase. Drain before each register
      // load; the last phase runs with no idling on either side.
      for (int p = 0; p < NumPhases; p++) begin
         if (p > 0) begin
            settle();
            load_timing(p);
         end
         calm       = (p == NumPhases - 1);
         first_word = words_sent;
         while (words_sent - first_word < PhaseWords[p]) begin
            if ($urandom_range(7) == 0) begin
               req_pct = ReqIdlePct[$urandom_range(2)];
               rsp_pct = RspIdlePct[$urandom_range(2)];
            end
            if ($urandom_range(99) < 75)
               send_frame(random_frame(),
                          ($urandom_range(99) < 15) ?
                             int'($urandom_range(pwsfd_pkg::FrameBits)) : -1);
            else
               send_noise();
         end
      end

      // drop valid, then wait for the last status words
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d request words over %0d timing settings, %0d status words checked",
               words_sent, NumPhases, readings_checked);
      $display("%0d frames decoded cleanly, %0d of them short format, %0d mismatches",
               good_frames, short_frames, mismatch_count);
      if (mismatch_count == 0)
         $display("pulse_width_sensor_frame_decoder_test passed");
      else
         $display("pulse_width_sensor_frame_decoder_test failed");
      $finish;
   end

endmodule

### files.f
rtl/pwsfd_pkg.sv
rtl/pwsfd_bounds.sv
rtl/pulse_width_sensor_frame_decoder.sv
sim/pulse_width_sensor_frame_decoder_test.sv
